@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication that checks the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sm4_pkg.sv @@
// ----------------------------------------------------------------------------
// SM4 package
// Shared constants, types, the S-box table and the round function.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int WORD_W         = 32;
  localparam int BLOCK_W        = 64;
  localparam int KEY_AW         = 5;
  localparam int NUM_ROUNDS_DEF = 32;

  // Request codes carried on the op port.
  localparam logic OP_KEY_WRITE = 1'b0;
  localparam logic OP_ENCRYPT   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } dp_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // Byte-wise S-box substitution of one word.
  function automatic logic [WORD_W-1:0] sm4_tau(input logic [WORD_W-1:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // Linear diffusion: xor of the word and its left rotations by 2, 10, 18, 24.
  function automatic logic [WORD_W-1:0] sm4_lin(input logic [WORD_W-1:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
             ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

endpackage

@@ rtl/sm4_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// SM4 block encryption: requests are accepted only while idle, and an encrypt
// request gives its result strobe after its last round; a key write gives none.
// The loop is one round per cycle through the round datapath, fed by the key
// memory, whose registered read is issued in the cycle before its round.
// Synchronous reset returns the sequencer to idle; round keys are not cleared.
// ----------------------------------------------------------------------------
module sm4_block_encrypt
  import sm4_pkg::*;
#(
  parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [KEY_AW-1:0]  key_index,
  input  logic [WORD_W-1:0]  round_key,
  input  logic [BLOCK_W-1:0] block_high,
  input  logic [BLOCK_W-1:0] block_low,
  output logic               done,
  output logic [BLOCK_W-1:0] cipher_high,
  output logic [BLOCK_W-1:0] cipher_low
);

  localparam int RW = $clog2(NUM_ROUNDS);

  state_t            state;
  state_t            state_next;
  logic [RW-1:0]     rnd;
  logic [RW-1:0]     rnd_next;
  logic [RW:0]       rnd_inc;
  logic              accept;
  logic              key_wr;
  logic              enc_start;
  logic [KEY_AW-1:0] rd_addr;
  logic [WORD_W-1:0] key;
  dp_ctrl_t          ctrl;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
    end
  end

  // Request decode, next state and datapath controls.
  always_comb begin
    busy      = (state == ST_RUN);
    accept    = start && !busy;
    key_wr    = accept && (op == OP_KEY_WRITE);
    enc_start = accept && (op == OP_ENCRYPT);
    rnd_inc   = {1'b0, rnd} + (RW+1)'(1);

    ctrl.load = enc_start;
    ctrl.step = 1'b0;
    ctrl.last = (rnd == RW'(NUM_ROUNDS - 1));

    state_next = state;
    rnd_next   = rnd;
    rd_addr    = '0;

    case (state)
      ST_IDLE: begin
        // The first round key is fetched while the block is loaded.
        rnd_next = '0;
        if (enc_start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl.step = 1'b1;
        rd_addr   = KEY_AW'(rnd_inc);
        rnd_next  = rnd_inc[RW-1:0];
        if (ctrl.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  sm4_key_mem u_key_mem (
    .clk     (clk),
    .wr_en   (key_wr),
    .wr_addr (key_index),
    .wr_data (round_key),
    .rd_addr (rd_addr),
    .rd_data (key)
  );

  sm4_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .block_high  (block_high),
    .block_low   (block_low),
    .key         (key),
    .done        (done),
    .cipher_high (cipher_high),
    .cipher_low  (cipher_low)
  );

endmodule

@@ rtl/sm4_key_mem.sv @@
// ----------------------------------------------------------------------------
// SM4 round key memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sm4_key_mem
  import sm4_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [KEY_AW-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [KEY_AW-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [2**KEY_AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sm4_datapath.sv @@
// ----------------------------------------------------------------------------
// SM4 round datapath
// Holds the four working words, applies one round per step and registers the
// reversed final words as the ciphertext.
// ----------------------------------------------------------------------------
module sm4_datapath
  import sm4_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_ctrl_t           ctrl,
  input  logic [BLOCK_W-1:0] block_high,
  input  logic [BLOCK_W-1:0] block_low,
  input  logic [WORD_W-1:0]  key,
  output logic               done,
  output logic [BLOCK_W-1:0] cipher_high,
  output logic [BLOCK_W-1:0] cipher_low
);

  logic [WORD_W-1:0] x0;
  logic [WORD_W-1:0] x1;
  logic [WORD_W-1:0] x2;
  logic [WORD_W-1:0] x3;
  logic [WORD_W-1:0] nx;

  // Round function on the current words and the round key from memory.
  always_comb begin
    nx = x0 ^ sm4_lin(sm4_tau(x1 ^ x2 ^ x3 ^ key));
  end

  // Working words: loaded on a new block, shifted once per round.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x0 <= block_high[63:32];
      x1 <= block_high[31:0];
      x2 <= block_low[63:32];
      x3 <= block_low[31:0];
    end else if (ctrl.step) begin
      x0 <= x1;
      x1 <= x2;
      x2 <= x3;
      x3 <= nx;
    end
  end

  // Output registers take the reversed words after the last round.
  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.last) begin
      cipher_high <= {nx, x3};
      cipher_low  <= {x2, x1};
    end
  end

  // Result strobe, high for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.step && ctrl.last;
    end
  end

endmodule

@@ rtl/sm4_chk.sv @@
// ----------------------------------------------------------------------------
// SM4 port checker
// Watches the request and result handshake of the top level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sm4_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic op,
  input logic done
);

  // An accepted encrypt request occupies the block on the next cycle.
  `ASSERT_NEXT(enc_sets_busy, clk, rst, start && !busy && op, busy)

  // A key write request neither occupies the block nor gives a result.
  `ASSERT_NEXT(key_wr_no_result, clk, rst, start && !busy && !op, !busy && !done)

  // The block frees itself exactly when the result is presented.
  `ASSERT_IMPL(busy_fall_done, clk, rst, $fell(busy) && !$past(rst), done)

  // A result only follows a busy period, never one taken while busy.
  `ASSERT_IMPL(done_after_busy, clk, rst, done, !busy && $past(busy))

  // The result strobe lasts a single cycle.
  `ASSERT_NEXT(done_one_cycle, clk, rst, done, !done)

endmodule

bind sm4_block_encrypt sm4_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .op    (op),
  .done  (done)
);
